@@ hdl/assert_macros.svh @@
// Assertion macros shared by the voltage monitor RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// Check a boolean expression at every clock edge outside reset.
`define AST_ALWAYS(label, clk, rst, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (expr)) \
      else $error("assertion failed");

// Check that the consequent holds whenever the antecedent holds.
`define AST_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

`else

`define AST_ALWAYS(label, clk, rst, expr)
`define AST_IMPLY(label, clk, rst, ante, cons)

`endif

`endif

@@ hdl/tpvm_pkg.sv @@
// Types and constants of the three-phase voltage monitor.
`default_nettype none

package tpvm_pkg;

   localparam int PHASES    = 3;
   localparam int VOLT_W    = 16;
   localparam int SUM_W     = 18;      // sum of three voltages, also 3*v
   localparam int NUM_W     = 32;      // deviation times scale
   localparam int QUO_W     = 15;      // unbalance, 0.01 % units
   localparam int STAT_W    = 2;
   localparam int CSR_IDX_W = 2;
   localparam int SCALE     = 10000;
   localparam int MIN_SUM   = 30;      // mean of 1 V in 0.1 V units, times 3
   localparam int MAX_UNBAL = 20000;

   localparam logic [VOLT_W-1:0] LOST_RESET  = VOLT_W'(800);
   localparam logic [VOLT_W-1:0] UNDER_RESET = VOLT_W'(1800);
   localparam logic [VOLT_W-1:0] OVER_RESET  = VOLT_W'(2400);

   localparam logic [CSR_IDX_W-1:0] CSR_LOST  = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_UNDER = CSR_IDX_W'(1);
   localparam logic [CSR_IDX_W-1:0] CSR_OVER  = CSR_IDX_W'(2);

   typedef enum logic [STAT_W-1:0] {
      ST_OK    = 2'd0,
      ST_LOST  = 2'd1,
      ST_UNDER = 2'd2,
      ST_OVER  = 2'd3
   } status_type;

   typedef struct packed {
      logic [VOLT_W-1:0] lost;
      logic [VOLT_W-1:0] under;
      logic [VOLT_W-1:0] over;
   } thr_type;

   // One beat travelling down the divider chain.
   typedef struct packed {
      logic [PHASES-1:0][STAT_W-1:0] status;
      logic [SUM_W-1:0]              den;
      logic [NUM_W-1:0]              rem;
      logic [QUO_W-1:0]              quo;
   } div_type;

endpackage

`default_nettype wire

@@ hdl/tpvm_front.sv @@
// Front stages: phase status, sum, largest deviation and scaled numerator.
`default_nettype none

module tpvm_front import tpvm_pkg::*; (
   input  logic                         clock,
   input  logic                         reset,
   input  thr_type                      thr,
   input  logic                         in_valid,
   output logic                         in_ready,
   input  logic [PHASES-1:0][VOLT_W-1:0] volt,
   input  logic [PHASES-1:0]            ok,
   output logic                         out_valid,
   input  logic                         out_ready,
   output div_type                      out_data
);

   function automatic logic [STAT_W-1:0] classify(input logic [VOLT_W-1:0] v,
                                                  input logic okay,
                                                  input thr_type t);
      status_type s;
      if (!okay)           s = ST_LOST;
      else if (v < t.lost)  s = ST_LOST;
      else if (v < t.under) s = ST_UNDER;
      else if (v > t.over)  s = ST_OVER;
      else                  s = ST_OK;
      return s;
   endfunction

   // stage a
   logic                          vld_a_ff, vld_a_in;
   logic [PHASES-1:0][STAT_W-1:0] stat_a_ff, stat_a_in;
   logic [PHASES-1:0][SUM_W-1:0]  tri_a_ff, tri_a_in;
   logic [SUM_W-1:0]              sum_a_ff, sum_a_in;
   logic                          zero_a_ff, zero_a_in;
   // stage b
   logic                          vld_b_ff, vld_b_in;
   logic [PHASES-1:0][STAT_W-1:0] stat_b_ff;
   logic [SUM_W-1:0]              sum_b_ff;
   logic                          zero_b_ff;
   logic [SUM_W-1:0]              dmax_b_ff, dmax_b_in;
   // stage c
   logic                          vld_c_ff, vld_c_in;
   div_type                       data_c_ff, data_c_in;

   logic rdy_a, rdy_b, rdy_c;
   logic [PHASES-1:0][SUM_W-1:0] diff;

   assign rdy_c    = ~vld_c_ff | out_ready;
   assign rdy_b    = ~vld_b_ff | rdy_c;
   assign rdy_a    = ~vld_a_ff | rdy_b;
   assign in_ready = rdy_a;

   assign vld_a_in = rdy_a ? in_valid : vld_a_ff;
   assign vld_b_in = rdy_b ? vld_a_ff : vld_b_ff;
   assign vld_c_in = rdy_c ? vld_b_ff : vld_c_ff;

   always_comb begin
      sum_a_in = '0;
      for (int p = 0; p < PHASES; p++) begin
         stat_a_in[p] = classify(volt[p], ok[p], thr);
         tri_a_in[p]  = (SUM_W'(volt[p]) << 1) + SUM_W'(volt[p]);
         sum_a_in     = sum_a_in + SUM_W'(volt[p]);
      end
      zero_a_in = ~(&ok) | (sum_a_in < SUM_W'(MIN_SUM));
   end

   always_comb begin
      dmax_b_in = '0;
      for (int p = 0; p < PHASES; p++) begin
         diff[p] = (tri_a_ff[p] >= sum_a_ff) ? tri_a_ff[p] - sum_a_ff
                                             : sum_a_ff - tri_a_ff[p];
         if (diff[p] > dmax_b_in) dmax_b_in = diff[p];
      end
   end

   always_comb begin
      data_c_in.status = stat_b_ff;
      data_c_in.quo    = '0;
      // force a harmless divisor when the unbalance is zero
      data_c_in.den    = zero_b_ff ? SUM_W'(1) : sum_b_ff;
      data_c_in.rem    = zero_b_ff ? '0 : NUM_W'(dmax_b_ff) * NUM_W'(SCALE);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_a_ff <= 1'b0;
         vld_b_ff <= 1'b0;
         vld_c_ff <= 1'b0;
      end else begin
         vld_a_ff <= vld_a_in;
         vld_b_ff <= vld_b_in;
         vld_c_ff <= vld_c_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && rdy_a) begin
         stat_a_ff <= stat_a_in;
         tri_a_ff  <= tri_a_in;
         sum_a_ff  <= sum_a_in;
         zero_a_ff <= zero_a_in;
      end
      if (vld_a_ff && rdy_b) begin
         stat_b_ff <= stat_a_ff;
         sum_b_ff  <= sum_a_ff;
         zero_b_ff <= zero_a_ff;
         dmax_b_ff <= dmax_b_in;
      end
      if (vld_b_ff && rdy_c) begin
         data_c_ff <= data_c_in;
      end
   end

   assign out_valid = vld_c_ff;
   assign out_data  = data_c_ff;

endmodule

`default_nettype wire

@@ hdl/tpvm_div_cell.sv @@
// One restoring-division cell: settles one quotient bit per beat.
`default_nettype none

`include "assert_macros.svh"

module tpvm_div_cell import tpvm_pkg::*; #(
   parameter int STEP = 0
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    in_valid,
   output logic    in_ready,
   input  div_type in_data,
   output logic    out_valid,
   input  logic    out_ready,
   output div_type out_data
);

   logic             vld_ff, vld_in;
   div_type          data_ff, data_in;
   logic [NUM_W-1:0] shifted;
   logic             fits;

   assign in_ready = ~vld_ff | out_ready;
   assign vld_in   = in_ready ? in_valid : vld_ff;

   always_comb begin
      shifted = NUM_W'(in_data.den) << STEP;
      fits    = in_data.rem >= shifted;
      data_in = in_data;
      if (fits) data_in.rem = in_data.rem - shifted;
      data_in.quo[STEP] = fits;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = vld_ff;
   assign out_data  = data_ff;

   // remainder must stay below the divisor at this bit weight
   `AST_IMPLY(a_rem_bound, clock, reset, vld_ff, (data_ff.rem >> STEP) < NUM_W'(data_ff.den))
   `AST_IMPLY(a_den_nonzero, clock, reset, vld_ff, data_ff.den != '0)

endmodule

`default_nettype wire

@@ hdl/three_phase_voltage_monitor.sv @@
// Top level of the three-phase voltage monitor.
`default_nettype none

`include "assert_macros.svh"

// Three-phase voltage monitor. Each request beat carries three phase voltages
// in 0.1 V units with a valid flag per phase; each response beat carries a
// 2-bit status per phase (ok, lost, under, over) and the NEMA unbalance in
// 0.01 % units, floor(max|3v - sum| * 10000 / sum), zero when a phase is
// invalid or the mean is below 1 V. The block takes one beat per clock while
// responses are accepted and passes each beat through three front stages
// (status and sum, largest deviation, scaling multiply) and then a chain of
// 15 division cells, each settling one quotient bit. Every stage has its own
// valid flag and stalls only when the stage after it is full, so a waiting
// response does not block new requests until the whole chain has filled.
// Thresholds are written through the csr port (index 0 lost, 1 under, 2 over,
// other indexes ignored) and must only change while no beat is in flight.
module three_phase_voltage_monitor import tpvm_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   // request channel
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic [VOLT_W-1:0]    req_voltage_r,
   input  logic [VOLT_W-1:0]    req_voltage_s,
   input  logic [VOLT_W-1:0]    req_voltage_t,
   input  logic                 req_valid_r,
   input  logic                 req_valid_s,
   input  logic                 req_valid_t,
   // response channel
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [STAT_W-1:0]    rsp_status_r,
   output logic [STAT_W-1:0]    rsp_status_s,
   output logic [STAT_W-1:0]    rsp_status_t,
   output logic [QUO_W-1:0]     rsp_unbalance,
   // threshold writes
   input  logic                 csr_wen,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [VOLT_W-1:0]    csr_wdata
);

   thr_type thr_ff, thr_in;

   // Hold thresholds; drop writes to unused indexes.
   always_comb begin
      thr_in = thr_ff;
      if (csr_wen) begin
         case (csr_index)
            CSR_LOST:  thr_in.lost  = csr_wdata;
            CSR_UNDER: thr_in.under = csr_wdata;
            CSR_OVER:  thr_in.over  = csr_wdata;
            default:   thr_in       = thr_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff.lost  <= LOST_RESET;
         thr_ff.under <= UNDER_RESET;
         thr_ff.over  <= OVER_RESET;
      end else begin
         thr_ff <= thr_in;
      end
   end

   // Chain position 0 is the front output, position QUO_W the response.
   div_type                 chain_data [QUO_W+1];
   logic [QUO_W:0]          chain_vld;
   logic [QUO_W:0]          chain_rdy;

   tpvm_front u_front (
      .clock     (clock),
      .reset     (reset),
      .thr       (thr_ff),
      .in_valid  (req_valid),
      .in_ready  (req_ready),
      .volt      ({req_voltage_t, req_voltage_s, req_voltage_r}),
      .ok        ({req_valid_t, req_valid_s, req_valid_r}),
      .out_valid (chain_vld[0]),
      .out_ready (chain_rdy[0]),
      .out_data  (chain_data[0])
   );

   // Advance one quotient bit per cell, most significant bit first.
   for (genvar i = 0; i < QUO_W; i++) begin : g_cell
      tpvm_div_cell #(
         .STEP (QUO_W - 1 - i)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (chain_vld[i]),
         .in_ready  (chain_rdy[i]),
         .in_data   (chain_data[i]),
         .out_valid (chain_vld[i+1]),
         .out_ready (chain_rdy[i+1]),
         .out_data  (chain_data[i+1])
      );
   end

   assign chain_rdy[QUO_W] = rsp_ready;
   assign rsp_valid        = chain_vld[QUO_W];
   assign rsp_status_r     = chain_data[QUO_W].status[0];
   assign rsp_status_s     = chain_data[QUO_W].status[1];
   assign rsp_status_t     = chain_data[QUO_W].status[2];
   assign rsp_unbalance    = chain_data[QUO_W].quo;

   // deviation is at most twice the mean, so the quotient stays in range
   `AST_IMPLY(a_unbal_range, clock, reset, rsp_valid, rsp_unbalance <= QUO_W'(MAX_UNBAL))
   // a front beat enters the divider chain with all quotient bits still clear
   `AST_IMPLY(a_front_quo_clear, clock, reset, chain_vld[0], chain_data[0].quo == '0)

endmodule

`default_nettype wire

@@ tb/tb_three_phase_voltage_monitor.sv @@
// Self-checking testbench for the three-phase voltage monitor.
`timescale 1ns / 100ps

module tb_three_phase_voltage_monitor import tpvm_pkg::*; ;

   // Cycles from request beat to response beat through the block.
   localparam int LATENCY        = 18;
   // Cycles without any beat before the run is declared hung.
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int RANDOM_PHASES  = 7;
   localparam int PHASE_ITEMS    = 90;
   // Index past the last threshold register; writes to it are dropped.
   localparam logic [CSR_IDX_W-1:0] CSR_NONE = CSR_IDX_W'(3);

   typedef struct packed {
      status_type       status_r;
      status_type       status_s;
      status_type       status_t;
      logic [QUO_W-1:0] unbalance;
   } phase_report_type;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_ready;
   logic [VOLT_W-1:0]    req_voltage_r = '0;
   logic [VOLT_W-1:0]    req_voltage_s = '0;
   logic [VOLT_W-1:0]    req_voltage_t = '0;
   logic                 req_valid_r = 1'b0;
   logic                 req_valid_s = 1'b0;
   logic                 req_valid_t = 1'b0;
   logic                 rsp_valid;
   logic                 rsp_ready = 1'b0;
   logic [STAT_W-1:0]    rsp_status_r;
   logic [STAT_W-1:0]    rsp_status_s;
   logic [STAT_W-1:0]    rsp_status_t;
   logic [QUO_W-1:0]     rsp_unbalance;
   logic                 csr_wen = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = CSR_LOST;
   logic [VOLT_W-1:0]    csr_wdata = '0;

   // Local copy of the threshold registers, kept in step with every write.
   logic [VOLT_W-1:0] thr_lost  = LOST_RESET;
   logic [VOLT_W-1:0] thr_under = UNDER_RESET;
   logic [VOLT_W-1:0] thr_over  = OVER_RESET;

   phase_report_type expected_reports[$];
   int               mismatches = 0;
   int               stalled_cycles = 0;
   // When set, both sides run without gaps.
   bit               steady = 1'b0;

   three_phase_voltage_monitor dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_voltage_r (req_voltage_r),
      .req_voltage_s (req_voltage_s),
      .req_voltage_t (req_voltage_t),
      .req_valid_r   (req_valid_r),
      .req_valid_s   (req_valid_s),
      .req_valid_t   (req_valid_t),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_status_r  (rsp_status_r),
      .rsp_status_s  (rsp_status_s),
      .rsp_status_t  (rsp_status_t),
      .rsp_unbalance (rsp_unbalance),
      .csr_wen       (csr_wen),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   // ---------------------------------------------------------------------
   // Prediction
   // ---------------------------------------------------------------------

   // Classify one phase: the first matching check wins, even when the
   // thresholds are out of order. A phase with no reading is lost.
   function automatic status_type phase_status(input logic [VOLT_W-1:0] volts,
                                               input logic present);
      if (!present) return ST_LOST;
      if (volts < thr_lost) return ST_LOST;
      if (volts < thr_under) return ST_UNDER;
      if (volts > thr_over) return ST_OVER;
      return ST_OK;
   endfunction

   // Status of each phase plus floor(max|3v - sum| * SCALE / sum); the
   // unbalance stays zero when a phase is missing or the mean is below 1 V.
   function automatic phase_report_type predict_report(
         input logic [VOLT_W-1:0] vr, vs, vt, input logic okr, oks, okt);
      phase_report_type rep;
      longint           volts[3];
      longint           sum;
      longint           dev;
      longint           worst;
      rep.status_r  = phase_status(vr, okr);
      rep.status_s  = phase_status(vs, oks);
      rep.status_t  = phase_status(vt, okt);
      rep.unbalance = '0;
      volts[0] = longint'(vr);
      volts[1] = longint'(vs);
      volts[2] = longint'(vt);
      sum = volts[0] + volts[1] + volts[2];
      if (okr && oks && okt && sum >= MIN_SUM) begin
         worst = 0;
         for (int i = 0; i < PHASES; i++) begin
            dev = 3 * volts[i] - sum;
            if (dev < 0) dev = -dev;
            if (dev > worst) worst = dev;
         end
         rep.unbalance = QUO_W'((worst * SCALE) / sum);
      end
      return rep;
   endfunction

   // ---------------------------------------------------------------------
   // Scoreboard: record each accepted request, match each response beat
   // against the oldest outstanding report. Sample at the edge only, so
   // every value seen is the one the block saw.
   // ---------------------------------------------------------------------

   task automatic check_field(input string name, input logic [15:0] want,
                              input logic [15:0] got);
      if (got !== want) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         mismatches++;
      end
   endtask

   always @(posedge clock) begin : scoreboard
      phase_report_type want;
      if (!reset) begin
         if (req_valid && req_ready)
            expected_reports.push_back(predict_report(req_voltage_r, req_voltage_s,
               req_voltage_t, req_valid_r, req_valid_s, req_valid_t));
         if (rsp_valid && rsp_ready) begin
            if (expected_reports.size() == 0) begin
               $error("response beat with no request outstanding");
               mismatches++;
            end else begin
               want = expected_reports.pop_front();
               check_field("status_r", 16'(want.status_r), 16'(rsp_status_r));
               check_field("status_s", 16'(want.status_s), 16'(rsp_status_s));
               check_field("status_t", 16'(want.status_t), 16'(rsp_status_t));
               check_field("unbalance", 16'(want.unbalance), 16'(rsp_unbalance));
            end
         end
      end
   end

   // Hang detection: count cycles in which neither channel moves a beat.
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
         stalled_cycles = 0;
      else
         stalled_cycles = stalled_cycles + 1;
      if (stalled_cycles >= WATCHDOG_LIMIT) begin
         $display("** three_phase_voltage_monitor: FAILED **");
         $finish;
      end
   end

   // ---------------------------------------------------------------------
   // Random helpers
   // ---------------------------------------------------------------------

   // Mostly back-to-back or short gaps, now and then a long one.
   function automatic int pick_gap();
      int roll;
      if (steady) return 0;
      roll = $urandom_range(0, 99);
      if (roll < 50) return 0;
      if (roll < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic logic [VOLT_W-1:0] near(input logic [VOLT_W-1:0] base);
      int v;
      v = int'(base) + $urandom_range(0, 2) - 1;
      if (v < 0) v = 0;
      if (v > 65535) v = 65535;
      return VOLT_W'(v);
   endfunction

   // Bias voltages toward a grid-like band and the threshold edges, with
   // full-range values so every bit toggles.
   function automatic logic [VOLT_W-1:0] pick_voltage();
      case ($urandom_range(0, 9)) inside
         [0:3]: return VOLT_W'($urandom_range(1900, 2600));
         4: return near(thr_lost);
         5: return near(thr_under);
         6: return near(thr_over);
         7: return VOLT_W'($urandom_range(0, 40));
         8: return ($urandom_range(0, 1) != 0) ? '1 : '0;
         default: return VOLT_W'($urandom);
      endcase
   endfunction

   function automatic logic pick_present();
      return $urandom_range(0, 9) != 0;
   endfunction

   // Hold rsp_ready high for a random run, then drop it for a random gap.
   initial begin : response_sink
      int hold;
      hold = 0;
      forever begin
         @(posedge clock);
         if (hold > 0)
            hold = hold - 1;
         else if (rsp_ready) begin
            hold = pick_gap();
            if (hold > 0) rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
            hold = $urandom_range(1, 12);
         end
      end
   end

   // ---------------------------------------------------------------------
   // Shared driver tasks. Each is entered and left right after a rising
   // edge; req_valid stays high across back-to-back beats.
   // ---------------------------------------------------------------------

   task automatic send_reading(input logic [VOLT_W-1:0] vr, vs, vt,
                               input logic okr, oks, okt);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_voltage_r <= vr;
      req_voltage_s <= vs;
      req_voltage_t <= vt;
      req_valid_r   <= okr;
      req_valid_s   <= oks;
      req_valid_t   <= okt;
      do @(posedge clock); while (!req_ready);
   endtask

   // Drop the request, wait for every outstanding report, then let the
   // pipeline empty before touching the thresholds.
   task automatic settle_pipeline();
      req_valid <= 1'b0;
      @(posedge clock);
      while (expected_reports.size() != 0) @(posedge clock);
      repeat (LATENCY + 2) @(posedge clock);
   endtask

   // Leaves csr_wen high; the caller drops it after its last write.
   task automatic write_register(input logic [CSR_IDX_W-1:0] idx,
                                 input logic [VOLT_W-1:0] value);
      csr_wen   <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      case (idx)
         CSR_LOST:  thr_lost  = value;
         CSR_UNDER: thr_under = value;
         CSR_OVER:  thr_over  = value;
         default: ;
      endcase
   endtask

   task automatic set_thresholds(input logic [VOLT_W-1:0] lost, under, over);
      settle_pipeline();
      write_register(CSR_LOST, lost);
      write_register(CSR_UNDER, under);
      write_register(CSR_OVER, over);
      csr_wen <= 1'b0;
   endtask

   // ---------------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------------

   // Reset thresholds: each boundary, missing phases, the 1 V mean floor,
   // the worst-case unbalance and full-scale voltages.
   task automatic test_reset_thresholds();
      send_reading(2300, 2300, 2300, 1, 1, 1);
      send_reading(799, 800, 1799, 1, 1, 1);
      send_reading(1800, 2400, 2401, 1, 1, 1);
      send_reading(0, 65535, 32768, 1, 1, 1);
      send_reading(65535, 65535, 65535, 1, 1, 1);
      send_reading(65535, 0, 0, 1, 1, 1);
      send_reading(10, 10, 9, 1, 1, 1);
      send_reading(10, 10, 10, 1, 1, 1);
      send_reading(0, 30, 0, 1, 1, 1);
      send_reading(2300, 2300, 2300, 0, 1, 1);
      send_reading(2300, 2300, 2300, 1, 0, 1);
      send_reading(2300, 2300, 2300, 1, 1, 0);
      send_reading(0, 0, 0, 0, 0, 0);
      send_reading(2200, 2310, 2395, 1, 1, 1);
      send_reading(16'h5555, 16'hAAAA, 1, 1, 1, 1);
   endtask

   // Thresholds at both ends of their range, then out of order so the
   // check order decides.
   task automatic test_threshold_extremes();
      set_thresholds(16'h0000, 16'h0000, 16'h0000);
      send_reading(0, 1, 65535, 1, 1, 1);
      set_thresholds(16'hFFFF, 16'hFFFF, 16'hFFFF);
      send_reading(65535, 65534, 0, 1, 1, 1);
      set_thresholds(3000, 1000, 500);
      send_reading(2999, 3000, 600, 1, 1, 1);
      send_reading(400, 3000, 65535, 1, 1, 1);
   endtask

   // A write past the last register must leave every threshold as it was.
   task automatic test_ignored_index();
      settle_pipeline();
      write_register(CSR_NONE, 16'h0000);
      csr_wen <= 1'b0;
      send_reading(2999, 3000, 501, 1, 1, 1);
      send_reading(999, 1000, 500, 1, 1, 1);
   endtask

   // Full rate on both sides to fill the divider chain.
   task automatic test_back_to_back();
      set_thresholds(LOST_RESET, UNDER_RESET, OVER_RESET);
      steady = 1'b1;
      repeat (60)
         send_reading(pick_voltage(), pick_voltage(), pick_voltage(),
                      pick_present(), pick_present(), pick_present());
      steady = 1'b0;
   endtask

   // Random readings under a series of threshold settings: reset values,
   // ordered grid-like sets and fully random sets.
   task automatic test_random_readings();
      logic [VOLT_W-1:0] lost;
      logic [VOLT_W-1:0] under;
      logic [VOLT_W-1:0] over;
      for (int p = 0; p < RANDOM_PHASES; p++) begin
         if (p == 0) begin
            lost  = LOST_RESET;
            under = UNDER_RESET;
            over  = OVER_RESET;
         end else if (p % 3 == 0) begin
            lost  = VOLT_W'($urandom);
            under = VOLT_W'($urandom);
            over  = VOLT_W'($urandom);
         end else begin
            lost  = VOLT_W'($urandom_range(0, 1500));
            under = lost + VOLT_W'($urandom_range(0, 1000));
            over  = under + VOLT_W'($urandom_range(0, 1500));
         end
         set_thresholds(lost, under, over);
         repeat (PHASE_ITEMS)
            send_reading(pick_voltage(), pick_voltage(), pick_voltage(),
                         pick_present(), pick_present(), pick_present());
      end
   endtask

   initial begin
      // Hold reset from time zero, then release it on an edge.
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      test_reset_thresholds();
      test_threshold_extremes();
      test_ignored_index();
      test_back_to_back();
      test_random_readings();

      // Drain every outstanding report before the verdict.
      settle_pipeline();
      if (mismatches == 0 && expected_reports.size() == 0)
         $display("** three_phase_voltage_monitor: PASSED **");
      else
         $display("** three_phase_voltage_monitor: FAILED **");
      $finish;
   end

endmodule
